FILE: design/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// shared widths, constants and types of the radial spotlight luminance core
// ----------------------------------------------------------------------------
package rsl_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int LUMA_BITS   = 16;
    localparam int CENTER_BITS = 14;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);

    // distance front end
    localparam int DIFF_W = ((COORD_BITS + 1 > CENTER_BITS) ? COORD_BITS + 1 : CENTER_BITS) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    // spotlight radius squared, 160 * 160
    localparam int INNER_LIMIT_SQ = 25600;
    localparam int S_W            = $clog2(INNER_LIMIT_SQ);
    localparam int FRAC_SHIFT     = 16;

    // square root chain
    localparam int ROOT_W = (S_W + FRAC_SHIFT + 1) / 2;
    localparam int N_W    = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    // scaling: 200.0 in q8, and 0.2 of it for the outer ring
    localparam int FULL_SCALE_Q8 = 51200;
    localparam int OUTER_FACTOR  = FULL_SCALE_Q8 / 5;
    localparam int FACTOR_W      = 16;
    localparam int PROD_W        = LUMA_BITS + FACTOR_W;

    // 51200 = 2^11 * 25
    localparam int DIV_SHIFT = 11;
    localparam int DIV_ODD   = 25;
    localparam int Q_W       = PROD_W - DIV_SHIFT;
    localparam int RECIP     = (2 ** Q_W) / DIV_ODD;
    localparam int RECIP_W   = $clog2(RECIP + 1);

    // register stages from input transaction to result register
    localparam int PIPE_DEPTH = 3 + ROOT_W + 3;

    typedef struct packed {
        logic [N_W-1:0]       n;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
        logic [LUMA_BITS-1:0] luma;
        logic                 in_spot;
    } rsl_sqrt_t;

endpackage

FILE: design/rsl_if.sv
// ----------------------------------------------------------------------------
// rsl channel interfaces
// valid/ready channels for pixels, results and configuration writes
// ----------------------------------------------------------------------------
interface rsl_pix_if;
    import rsl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [LUMA_BITS-1:0]  luma_in;

    modport source (output valid, output pixel_x, output pixel_y, output luma_in,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input luma_in,
                    output ready);
endinterface

interface rsl_luma_if;
    import rsl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LUMA_BITS-1:0] luma_out;

    modport source (output valid, output luma_out, input ready);
    modport sink   (input valid, input luma_out, output ready);
endinterface

interface rsl_cfg_if;
    import rsl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CENTER_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/rsl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsl_sqrt_cell
// one digit of the restoring square root, registered, with flow control
// ----------------------------------------------------------------------------
module rsl_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsl_pkg::rsl_sqrt_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rsl_pkg::rsl_sqrt_t out_data
);
    import rsl_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rsl_sqrt_t  data_reg;
    rsl_sqrt_t  data_next;
    logic       en;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // bring down the next two radicand bits and try root*4+1
    always_comb
    begin
        rem_sh = {in_data.rem[REM_W-3:0], in_data.n[N_W-1 -: 2]};
        trial  = REM_W'({in_data.root, 2'b01});
        ge     = (rem_sh >= trial);

        data_next        = in_data;
        data_next.n      = {in_data.n[N_W-3:0], 2'b00};
        data_next.rem    = ge ? (rem_sh - trial) : rem_sh;
        data_next.root   = {in_data.root[ROOT_W-2:0], ge};
        valid_next       = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/rsl_scale.sv
// ----------------------------------------------------------------------------
// rsl_scale
// luminance times scale factor, then floor division by 51200 in three stages
// ----------------------------------------------------------------------------
module rsl_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rsl_pkg::rsl_sqrt_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rsl_pkg::LUMA_BITS-1:0] out_luma
);
    import rsl_pkg::*;

    logic                 a_valid_reg;
    logic [Q_W-1:0]       a_q_reg;
    logic [Q_W-1:0]       a_q_next;
    logic                 b_valid_reg;
    logic [Q_W-1:0]       b_q_reg;
    logic [RECIP_W-1:0]   b_e_reg;
    logic [RECIP_W-1:0]   b_e_next;
    logic                 c_valid_reg;
    logic [LUMA_BITS-1:0] c_luma_reg;
    logic [LUMA_BITS-1:0] c_luma_next;
    logic                 a_en;
    logic                 b_en;
    logic                 c_en;

    logic [FACTOR_W-1:0]      factor;
    logic [PROD_W-1:0]        prod;
    logic [Q_W+RECIP_W-1:0]   mq;
    logic [Q_W-1:0]           e25;
    logic [Q_W-1:0]           rem;
    logic [RECIP_W-1:0]       e_inc;

    assign c_en     = !c_valid_reg || out_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // stage a: product, low 11 bits dropped (the power-of-two part of 51200)
    always_comb
    begin
        factor   = in_data.in_spot ? FACTOR_W'(FULL_SCALE_Q8 - int'(in_data.root))
                                   : FACTOR_W'(OUTER_FACTOR);
        prod     = {{FACTOR_W{1'b0}}, in_data.luma} * {{LUMA_BITS{1'b0}}, factor};
        a_q_next = prod[PROD_W-1:DIV_SHIFT];
    end

    // stage b: quotient estimate by reciprocal, low by at most one
    always_comb
    begin
        mq       = {{RECIP_W{1'b0}}, a_q_reg} * {{Q_W{1'b0}}, RECIP_W'(RECIP)};
        b_e_next = mq[Q_W+RECIP_W-1:Q_W];
    end

    // stage c: one compare and increment
    always_comb
    begin
        e25         = Q_W'({{(Q_W-RECIP_W){1'b0}}, b_e_reg} * Q_W'(DIV_ODD));
        rem         = b_q_reg - e25;
        e_inc       = b_e_reg + RECIP_W'(1);
        c_luma_next = (rem >= Q_W'(DIV_ODD)) ? e_inc[LUMA_BITS-1:0]
                                             : b_e_reg[LUMA_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_q_reg <= a_q_next;
        end
        if (b_en)
        begin
            b_q_reg <= a_q_reg;
            b_e_reg <= b_e_next;
        end
        if (c_en)
        begin
            c_luma_reg <= c_luma_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_luma  = c_luma_reg;

endmodule

FILE: design/radial_spotlight_luminance_core.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luminance_core
// radial spotlight vignette on a pixel stream
// ----------------------------------------------------------------------------
// pipeline: 22 register stages (3 distance stages, 16 square root cells,
//   3 scaling stages)
// throughput: one pixel per cycle while results are taken; every stage is one
//   register that moves when its successor has room, so a stalled result only holds back the
//   stages behind it once they are full
// reset: clears all stage valid bits and both centre registers to zero
// ----------------------------------------------------------------------------
module radial_spotlight_luminance_core (
    input  logic   clk,
    input  logic   rst_n,
    rsl_cfg_if.sink    cfg,
    rsl_pix_if.sink    pix,
    rsl_luma_if.source res
);
    import rsl_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    logic [CENTER_BITS-1:0] center_x_reg;
    logic [CENTER_BITS-1:0] center_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CENTER_X: center_x_reg <= cfg.data;
                CFG_CENTER_Y: center_y_reg <= cfg.data;
                default:      ;  // unknown index, write ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: |dx| and |dy|
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic                 s1_en;
    logic [MAG_W-1:0]     s1_adx_reg;
    logic [MAG_W-1:0]     s1_ady_reg;
    logic [LUMA_BITS-1:0] s1_luma_reg;
    logic [MAG_W-1:0]     s1_adx_next;
    logic [MAG_W-1:0]     s1_ady_next;
    logic [DIFF_W-1:0]    dx;
    logic [DIFF_W-1:0]    dy;
    logic [DIFF_W-1:0]    dx_neg;
    logic [DIFF_W-1:0]    dy_neg;

    always_comb
    begin
        // pixel coordinates zero extended, centre sign extended
        dx = {{(DIFF_W-COORD_BITS){1'b0}}, pix.pixel_x}
           - {{(DIFF_W-CENTER_BITS){center_x_reg[CENTER_BITS-1]}}, center_x_reg};
        dy = {{(DIFF_W-COORD_BITS){1'b0}}, pix.pixel_y}
           - {{(DIFF_W-CENTER_BITS){center_y_reg[CENTER_BITS-1]}}, center_y_reg};
        dx_neg = ~dx + DIFF_W'(1);
        dy_neg = ~dy + DIFF_W'(1);
        s1_adx_next = dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
        s1_ady_next = dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 2: squares
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    logic                 s2_en;
    logic [SQ_W-1:0]      s2_sqx_reg;
    logic [SQ_W-1:0]      s2_sqy_reg;
    logic [LUMA_BITS-1:0] s2_luma_reg;
    logic [SQ_W-1:0]      s2_sqx_next;
    logic [SQ_W-1:0]      s2_sqy_next;

    always_comb
    begin
        s2_sqx_next = {{MAG_W{1'b0}}, s1_adx_reg} * {{MAG_W{1'b0}}, s1_adx_reg};
        s2_sqy_next = {{MAG_W{1'b0}}, s1_ady_reg} * {{MAG_W{1'b0}}, s1_ady_reg};
    end

    // ------------------------------------------------------------------
    // stage 3: squared distance, spotlight test, radicand s * 65536
    // ------------------------------------------------------------------
    logic            s3_valid_reg;
    logic            s3_en;
    rsl_sqrt_t       s3_data_reg;
    rsl_sqrt_t       s3_data_next;
    logic [SUM_W-1:0] dist_sq;

    always_comb
    begin
        dist_sq = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
        s3_data_next.in_spot = (dist_sq < SUM_W'(INNER_LIMIT_SQ));
        // outside the spotlight the root is never used, truncation is harmless
        s3_data_next.n       = {{(N_W-S_W-FRAC_SHIFT){1'b0}}, dist_sq[S_W-1:0],
                                {FRAC_SHIFT{1'b0}}};
        s3_data_next.rem     = '0;
        s3_data_next.root    = '0;
        s3_data_next.luma    = s2_luma_reg;
    end

    // ------------------------------------------------------------------
    // front-end flow control, one ready chain back from the root chain
    // ------------------------------------------------------------------
    logic cell_valid [ROOT_W+1];
    logic cell_ready [ROOT_W+1];
    rsl_sqrt_t cell_data [ROOT_W+1];

    assign s3_en     = !s3_valid_reg || cell_ready[0];
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign pix.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_adx_reg  <= s1_adx_next;
            s1_ady_reg  <= s1_ady_next;
            s1_luma_reg <= pix.luma_in;
        end
        if (s2_en)
        begin
            s2_sqx_reg  <= s2_sqx_next;
            s2_sqy_reg  <= s2_sqy_next;
            s2_luma_reg <= s1_luma_reg;
        end
        if (s3_en)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    // ------------------------------------------------------------------
    // square root: one cell per root bit, two radicand bits per cell
    // ------------------------------------------------------------------
    assign cell_valid[0] = s3_valid_reg;
    assign cell_data[0]  = s3_data_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_cell
        rsl_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // scaling and result register
    // ------------------------------------------------------------------
    rsl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[ROOT_W]),
        .in_ready  (cell_ready[ROOT_W]),
        .in_data   (cell_data[ROOT_W]),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_luma  (res.luma_out)
    );

endmodule

FILE: design/rsl_checker.sv
// ----------------------------------------------------------------------------
// rsl_checker
// port-level checks of the radial spotlight luminance core
// ----------------------------------------------------------------------------
module rsl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rsl_pkg::LUMA_BITS-1:0] out_luma
);
    import rsl_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // transactions accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (out_acc && !in_acc)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_luma))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result without an accepted pixel");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

endmodule

bind radial_spotlight_luminance_core rsl_checker u_rsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_luma  (res.luma_out)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the radial spotlight luminance core against a cycle-free predictor:
// pixels go in through a bursty driver, attenuated luminance comes back
// through a monitor with a stalling ready pattern, and every result is
// compared in order with the value predicted at input acceptance
// ----------------------------------------------------------------------------
module testbench;
    import rsl_pkg::*;

    // spare register indexes, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    // spotlight geometry and scaling, kept independent of the package
    localparam int SPOT_RADIUS    = 160;
    localparam int SPOT_RADIUS_SQ = SPOT_RADIUS * SPOT_RADIUS;
    localparam int SCALE_Q8       = 200 * 256;
    localparam int OUTER_DIVISOR  = 5;

    localparam int COORD_MAX  = 2 ** COORD_BITS - 1;
    localparam int LUMA_MAX   = 2 ** LUMA_BITS - 1;
    localparam int CENTER_MIN = -(2 ** (CENTER_BITS - 1));
    localparam int CENTER_MAX = 2 ** (CENTER_BITS - 1) - 1;

    // random pixels mostly land within this many pixels of the centre
    localparam int NEAR_SPAN = 175;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 4000;
    localparam int RANDOM_PHASES    = 4;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [LUMA_BITS-1:0]  luma;
    } pixel_t;

    // ready patterns of the result receiver
    typedef enum logic [1:0] {
        RCV_OPEN,
        RCV_COIN,
        RCV_SPARSE,
        RCV_COMB
    } rcv_mode_t;

    logic clk;
    logic rst_n;

    rsl_cfg_if  cfg_if ();
    rsl_pix_if  pix_if ();
    rsl_luma_if res_if ();

    radial_spotlight_luminance_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .pix   (pix_if),
        .res   (res_if)
    );

    // testbench copy of the centre registers
    logic signed [CENTER_BITS-1:0] spot_cx = '0;
    logic signed [CENTER_BITS-1:0] spot_cy = '0;

    // pixels waiting to be driven, luminance values waiting to come back
    pixel_t               pixel_q[$];
    logic [LUMA_BITS-1:0] luma_expect_q[$];

    int err_cnt = 0;

    // driver burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver state
    rcv_mode_t            rcv_mode      = RCV_OPEN;
    int                   rcv_mode_left = 0;
    int                   rcv_tick      = 0;
    int                   hold_left     = 0;
    int                   long_hold_reqs = 0;
    int                   long_hold_seen = 0;
    logic [LUMA_BITS-1:0] luma_exp;

    int quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // predictor: attenuated luminance of one pixel under the current centre
    // ------------------------------------------------------------------------
    function automatic logic [LUMA_BITS-1:0] spotlight_luma(pixel_t p);
        longint                dx;
        longint                dy;
        longint                dist_sq;
        longint unsigned       scaled_sq;
        longint unsigned       root;
        longint unsigned       trial;
        longint unsigned       luma_w;
        int                    b;
        dx       = longint'(p.x) - longint'(spot_cx);
        dy       = longint'(p.y) - longint'(spot_cy);
        dist_sq  = dx * dx + dy * dy;
        luma_w   = p.luma;
        // on the rim or beyond: flat 0.2 factor
        if (dist_sq >= SPOT_RADIUS_SQ)
            return LUMA_BITS'(luma_w / OUTER_DIVISOR);
        // distance with 8 fraction bits, truncated, found bit by bit
        scaled_sq = dist_sq;
        scaled_sq = scaled_sq << 16;
        root      = 0;
        for (b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled_sq)
                root = trial;
        end
        return LUMA_BITS'((luma_w * (SCALE_Q8 - root)) / SCALE_Q8);
    endfunction

    // random pixel, mostly around the spotlight so both regions get exercised
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     px;
        int     py;
        if ($urandom_range(0, 9) < 7)
        begin
            px = int'(spot_cx) + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
            py = int'(spot_cy) + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
            px = (px < 0) ? 0 : ((px > COORD_MAX) ? COORD_MAX : px);
            py = (py < 0) ? 0 : ((py > COORD_MAX) ? COORD_MAX : py);
        end
        else
        begin
            px = $urandom_range(0, COORD_MAX);
            py = $urandom_range(0, COORD_MAX);
        end
        p.x = COORD_BITS'(px);
        p.y = COORD_BITS'(py);
        case ($urandom_range(0, 15))
            0:       p.luma = '0;
            1:       p.luma = '1;
            default: p.luma = LUMA_BITS'($urandom_range(0, LUMA_MAX));
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one register write transaction, the local copy follows on acceptance
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CENTER_BITS-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_CENTER_X: spot_cx = value;
            CFG_CENTER_Y: spot_cy = value;
            default:      ;
        endcase
    endtask

    task automatic set_center(input int cx, input int cy);
        cfg_write(CFG_CENTER_X, CENTER_BITS'(cx));
        cfg_write(CFG_CENTER_Y, CENTER_BITS'(cy));
    endtask

    task automatic push_pixel(input int x, input int y, input int luma);
        pixel_t p;
        p.x    = COORD_BITS'(x);
        p.y    = COORD_BITS'(y);
        p.luma = LUMA_BITS'(luma);
        pixel_q.push_back(p);
    endtask

    task automatic fill_random(input int count);
        repeat (count)
            pixel_q.push_back(random_pixel());
    endtask

    // sampled at the falling edge so every update of the rising edge has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || pix_if.valid || luma_expect_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // pixel driver: bursts of random length with random gaps in between
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
        end
        else if (pix_if.valid && !pix_if.ready)
        begin
            // transaction still pending, hold it
        end
        else
        begin
            // predict on acceptance, under the centre in force right now
            if (pix_if.valid)
                luma_expect_q.push_back(spotlight_luma({pix_if.pixel_x, pix_if.pixel_y,
                                                        pix_if.luma_in}));
            if (gap_left > 0)
            begin
                gap_left--;
                pix_if.valid <= 1'b0;
            end
            else if (pixel_q.size() == 0)
            begin
                pix_if.valid <= 1'b0;
            end
            else
            begin
                pixel_t p;
                p = pixel_q.pop_front();
                pix_if.valid   <= 1'b1;
                pix_if.pixel_x <= p.x;
                pix_if.pixel_y <= p.y;
                pix_if.luma_in <= p.luma;
                burst_left--;
                if (burst_left == 0)
                begin
                    // a quarter of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (luma_expect_q.size() == 0)
                begin
                    $error("luma_out: unexpected result %0d", res_if.luma_out);
                    err_cnt++;
                end
                else
                begin
                    luma_exp = luma_expect_q.pop_front();
                    if (res_if.luma_out !== luma_exp)
                    begin
                        $error("luma_out mismatch: expected %0d, actual %0d",
                               luma_exp, res_if.luma_out);
                        err_cnt++;
                    end
                end
            end

            // a long hold-off lets the pipeline fill and back up into the input
            if (long_hold_seen != long_hold_reqs)
            begin
                long_hold_seen = long_hold_reqs;
                hold_left      = LONG_HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (rcv_mode_left == 0)
                begin
                    rcv_mode      = rcv_mode_t'($urandom_range(0, 3));
                    rcv_mode_left = $urandom_range(4, 60);
                end
                rcv_mode_left--;
                rcv_tick++;
                case (rcv_mode)
                    RCV_OPEN:   res_if.ready <= 1'b1;
                    RCV_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    RCV_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:    res_if.ready <= ((rcv_tick % 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed corners first, then random phases under many centres
    // ------------------------------------------------------------------------
    initial
    begin
        int rnd_cx;
        int rnd_cy;

        pix_if.valid   = 1'b0;
        pix_if.pixel_x = '0;
        pix_if.pixel_y = '0;
        pix_if.luma_in = '0;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // centre left at its reset value, the image corner
        push_pixel(0, 0, LUMA_MAX);                 // zero distance keeps full luma
        push_pixel(0, 0, 0);
        push_pixel(SPOT_RADIUS - 1, 0, LUMA_MAX);   // just inside the rim
        push_pixel(SPOT_RADIUS, 0, LUMA_MAX);       // on the rim counts as outside
        push_pixel(96, 128, 40000);                 // rim hit off axis
        push_pixel(95, 128, 1);
        push_pixel(COORD_MAX, COORD_MAX, LUMA_MAX);
        push_pixel(0, COORD_MAX, 1);
        fill_random(80);
        wait_idle();

        // centre inside the image, then spare indexes that must change nothing
        set_center(1000, 3000);
        cfg_write(CFG_SPARE_LO, '0);
        cfg_write(CFG_SPARE_HI, CENTER_BITS'($urandom));
        push_pixel(1000, 3000, LUMA_MAX - 1);
        push_pixel(1113, 3113, LUMA_MAX);           // diagonal, just inside
        push_pixel(840, 3000, LUMA_MAX);            // rim, negative dx
        push_pixel(1000, 2841, 12345);              // inside, negative dy
        push_pixel(872, 3096, 50000);               // rim, mixed signs
        push_pixel(999, 3001, LUMA_MAX);
        push_pixel(COORD_MAX, 0, LUMA_MAX);
        push_pixel(0, 0, 32768);
        fill_random(150);
        // receiver holds off while the driver keeps offering pixels
        @(negedge clk);
        long_hold_reqs++;
        wait_idle();

        // centres at the register extremes, far outside the image
        set_center(CENTER_MIN, CENTER_MIN);
        fill_random(60);
        wait_idle();

        set_center(CENTER_MAX, CENTER_MAX);
        fill_random(60);
        wait_idle();

        set_center(-4096, CENTER_MAX);
        fill_random(60);
        wait_idle();

        // centre on the right image border
        set_center(COORD_MAX, 0);
        push_pixel(COORD_MAX, SPOT_RADIUS - 1, LUMA_MAX);
        push_pixel(COORD_MAX, SPOT_RADIUS, LUMA_MAX);
        fill_random(100);
        wait_idle();

        // random centres, mostly in or near the image, sometimes any raw value
        repeat (RANDOM_PHASES)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                rnd_cx = $urandom_range(0, 2 ** CENTER_BITS - 1);
                rnd_cy = $urandom_range(0, 2 ** CENTER_BITS - 1);
            end
            else
            begin
                rnd_cx = int'($urandom_range(0, 4500)) - 200;
                rnd_cy = int'($urandom_range(0, 4500)) - 200;
            end
            set_center(rnd_cx, rnd_cy);
            fill_random(100);
            wait_idle();
        end

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (2 * PIPE_DEPTH + 8) @(posedge clk);
        if (luma_expect_q.size() != 0)
        begin
            $error("luma_out: %0d expected results never arrived", luma_expect_q.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/rsl_pkg.sv
design/rsl_if.sv
design/rsl_sqrt_cell.sv
design/rsl_scale.sv
design/radial_spotlight_luminance_core.sv
design/rsl_checker.sv
sim/testbench.sv
